// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ID table RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/bitr_pkg.sv =====
// Shared types and constants of the bounded ID table.
// No dependencies.
package bitr_pkg;

    localparam int unsigned ID_W     = 32;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CMD_W    = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ID_W-1:0]    id_value;
        logic [INDEX_W-1:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic [ID_W-1:0]     read_id;
    } out_item_t;

    // Operation class decided by the front end
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    id;
        logic [INDEX_W-1:0] index;
    } work_t;

    // Handshake between front end and queue
    typedef struct packed {
        logic  valid;
        work_t work;
    } push_t;

endpackage

// ===== rtl/bitr_front.sv =====
// Front end: accepts input transfers and classifies the command.
// Depends on bitr_pkg.
module bitr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bitr_pkg::in_item_t in_item,
    input  logic             q_full,
    output bitr_pkg::push_t  push
);
    import bitr_pkg::*;

    logic  f_valid_reg, f_valid_next;
    work_t f_work_reg;
    work_t f_work_cls;
    logic  accept;
    logic  push_go;

    // Classify the command
    always_comb
    begin
        f_work_cls.id    = in_item.id_value;
        f_work_cls.index = in_item.entry_index;
        case (in_item.command)
            CMD_INSERT: f_work_cls.op = OP_INSERT;
            CMD_REMOVE: f_work_cls.op = OP_REMOVE;
            CMD_READ:   f_work_cls.op = OP_READ;
            default:    f_work_cls.op = OP_NOP;
        endcase
    end

    assign in_stall = f_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push_go  = f_valid_reg && !q_full;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push_go)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_work_reg <= f_work_cls;
        end
    end

    assign push.valid = push_go;
    assign push.work  = f_work_reg;

endmodule

// ===== rtl/bitr_queue.sv =====
// Two-entry queue between the front end and the back end.
// Depends on bitr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bitr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  bitr_pkg::push_t push,
    output logic            full,
    output logic            q_valid,
    output bitr_pkg::work_t q_work,
    input  logic            pop
);
    import bitr_pkg::*;

    work_t      slot_reg [2];
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_work  = slot_reg[head_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && q_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        head_next = do_pop  ? ~head_reg : head_reg;
        tail_next = do_push ? ~tail_reg : tail_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= push.work;
        end
    end

    `ASSERT_NEVER(a_q_overflow, push.valid && full, "push into full queue")
    `ASSERT_NEVER(a_q_underflow, pop && !q_valid, "pop from empty queue")
    `ASSERT_CLK(a_q_fill, (fill_reg == 2'd0 && head_reg == tail_reg) || (fill_reg == 2'd2 && head_reg == tail_reg) || (fill_reg == 2'd1 && head_reg != tail_reg), "queue pointers disagree with fill")

endmodule

// ===== rtl/bitr_back.sv =====
// Back end: ID store, count, scan and swap sequencer, result register.
// Depends on bitr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bitr_back #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cap_we,
    input  logic [bitr_pkg::COUNT_W-1:0] cap_data,
    input  logic                         q_valid,
    input  bitr_pkg::work_t              q_work,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bitr_pkg::out_item_t          out_item
);
    import bitr_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_SWAP_RD = 6'b000100,
        S_SWAP_WR = 6'b001000,
        S_RDWAIT  = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [COUNT_W-1:0]  cap_reg;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       cmp_pos_reg, cmp_pos_next;
    logic [AW-1:0]       hit_pos_reg, hit_pos_next;
    logic [ID_W-1:0]     cur_id_reg, cur_id_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic [ID_W-1:0]     mem [DEPTH];
    logic [ID_W-1:0]     rdata_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [ID_W-1:0]     mem_wd;

    logic [CW-1:0]       last;
    logic [AW-1:0]       last_a;
    logic                at_limit;
    logic                idx_ok;
    logic                out_free;
    logic                hit;

    assign last     = count_reg - CW'(1);
    assign last_a   = last[AW-1:0];
    assign at_limit = (LW'(count_reg) >= LW'(cap_reg)) || (LW'(count_reg) >= LW'(DEPTH));
    assign idx_ok   = (LW'(q_work.index) < LW'(count_reg)) && (LW'(q_work.index) < LW'(DEPTH));
    assign out_free = !out_valid_reg || !out_stall;
    assign hit      = cmp_valid_reg && (rdata_reg == cur_id_reg);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        cmp_valid_next   = 1'b0;
        cmp_pos_next     = cmp_pos_reg;
        hit_pos_next     = hit_pos_reg;
        cur_id_next      = cur_id_reg;
        pend_status_next = pend_status_reg;
        pend_id_next     = pend_id_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_next         = out_reg;
        pop              = 1'b0;
        rd_addr          = AW'(q_work.index);
        mem_we           = 1'b0;
        mem_wa           = count_reg[AW-1:0];
        mem_wd           = q_work.id;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop              = 1'b1;
                    cur_id_next      = q_work.id;
                    pend_status_next = ST_OK;
                    pend_id_next     = '0;
                    state_next       = S_FINISH;
                    case (q_work.op)
                        OP_INSERT:
                        begin
                            if (at_limit)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                pend_status_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            pend_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle, compare the previous one
                rd_addr = ptr_reg[AW-1:0];
                if (ptr_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_pos_next   = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg + CW'(1);
                end
                if (hit)
                begin
                    cmp_valid_next   = 1'b0;
                    pend_status_next = ST_OK;
                    if (cmp_pos_reg == last_a)
                    begin
                        count_next = last;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        hit_pos_next = cmp_pos_reg;
                        state_next   = S_SWAP_RD;
                    end
                end
                else if (cmp_valid_reg && cmp_pos_reg == last_a)
                begin
                    cmp_valid_next   = 1'b0;
                    pend_status_next = ST_NOT_FOUND;
                    state_next       = S_FINISH;
                end
            end
            S_SWAP_RD:
            begin
                rd_addr    = last_a;
                state_next = S_SWAP_WR;
            end
            S_SWAP_WR:
            begin
                // last entry moves into the hole
                mem_we     = 1'b1;
                mem_wa     = hit_pos_reg;
                mem_wd     = rdata_reg;
                count_next = last;
                state_next = S_FINISH;
            end
            S_RDWAIT:
            begin
                pend_id_next = rdata_reg;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = pend_status_reg;
                    out_next.entry_count = COUNT_W'(count_reg);
                    out_next.read_id     = pend_id_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= COUNT_W'(64);
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cap_we)
            begin
                cap_reg <= cap_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        cmp_pos_reg     <= cmp_pos_next;
        hit_pos_reg     <= hit_pos_next;
        cur_id_reg      <= cur_id_next;
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        out_reg         <= out_next;
    end

    // ID store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    `ASSERT_NEVER(a_count_max, count_reg > CW'(DEPTH), "count beyond depth")
    `ASSERT_CLK(a_count_step, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1)) || (count_reg + CW'(1) == $past(count_reg)), "count moved by more than one")
    `ASSERT_NEVER(a_write_state, mem_we && !(state_reg == S_IDLE || state_reg == S_SWAP_WR), "store written outside insert or swap")

endmodule

// ===== rtl/bounded_id_table_swap_remove_unit.sv =====
// Remove time grows with the entry count, set by the one-entry-per-cycle scan of the
// single-read-port ID store. The back end takes a new item only after the last one is
// finished; the front end and the two-entry queue hold new items meanwhile.
// Reset (rst_n, async, active low): table empty, capacity 64, no clearing pass.
// Top level: front end, two-entry queue, back end with store and result register.
// Depends on bitr_pkg, bitr_front, bitr_queue, bitr_back.
module bounded_id_table_swap_remove_unit #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bitr_pkg::in_item_t           in_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bitr_pkg::out_item_t          out_item,
    input  logic                         cfg_we,
    input  logic [bitr_pkg::COUNT_W-1:0] cfg_data
);
    import bitr_pkg::*;

    push_t push;
    logic  q_full;
    logic  q_valid;
    work_t q_work;
    logic  q_pop;

    bitr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .push     (push)
    );

    bitr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_work  (q_work),
        .pop     (q_pop)
    );

    bitr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_we    (cfg_we),
        .cap_data  (cfg_data),
        .q_valid   (q_valid),
        .q_work    (q_work),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
